// ===== sv/iqhist_pkg.sv =====
// Shared types, constants and helper functions of the sample histogram block.
package iqhist_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int BIN_COUNT   = 65536;
  localparam int BIN_BITS    = $clog2(BIN_COUNT);
  localparam int COUNT_BITS  = 40;
  localparam int OUT_BITS    = 40;

  typedef logic [BIN_BITS-1:0]          bin_addr_t;
  typedef logic [COUNT_BITS-1:0]        count_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam count_t COUNT_MAX = '1;

  typedef enum logic {
    MODE_ACCUMULATE = 1'b0,
    MODE_QUERY      = 1'b1
  } mode_t;

  typedef struct packed {
    logic      rd;
    logic      chan;
    bin_addr_t addr;
    logic      ok;
    logic      accumulate;
    logic      count_en;
  } bin_req_t;

  function automatic logic signed [SAMPLE_BITS+1:0] bin_offset(input sample_t v);
    return (SAMPLE_BITS+2)'(v) + (SAMPLE_BITS+2)'(BIN_COUNT / 2);
  endfunction

  function automatic logic bin_in_range(input logic signed [SAMPLE_BITS+1:0] off);
    return (off >= 0) && (off < $signed((SAMPLE_BITS+2)'(BIN_COUNT)));
  endfunction

  function automatic count_t sat_inc(input count_t c);
    return (c == COUNT_MAX) ? c : c + count_t'(1);
  endfunction

  function automatic logic [OUT_BITS-1:0] to_out(input count_t c);
    logic [63:0] w;
    w = 64'(c);
    return w[OUT_BITS-1:0];
  endfunction

endpackage

// ===== sv/iqhist_bins.sv =====
// Histogram bin memories with read-modify-write, forwarding and the clearing pass.
module iqhist_bins (
  input  logic                clk,
  input  logic                rst,
  input  iqhist_pkg::bin_req_t req,
  input  logic                retire,
  output iqhist_pkg::count_t  count,
  output logic                clearing
);
  import iqhist_pkg::*;

  count_t    even_mem [BIN_COUNT];
  count_t    odd_mem  [BIN_COUNT];

  bin_addr_t clr_addr;
  logic      p_chan;
  bin_addr_t p_addr;
  logic      p_ok;
  logic      p_acc;
  logic      p_en;
  count_t    rd_even;
  count_t    rd_odd;
  logic      fwd;
  count_t    fwd_data;

  count_t    base;
  count_t    inc;
  logic      wr;
  logic      we_even;
  logic      we_odd;
  bin_addr_t waddr;
  count_t    wdata;

  always_comb begin
    base = fwd ? fwd_data : (p_chan ? rd_odd : rd_even);
    inc  = sat_inc(base);
    wr   = retire && p_acc && p_en && p_ok;
    if (clearing) begin
      we_even = 1'b1;
      we_odd  = 1'b1;
      waddr   = clr_addr;
      wdata   = '0;
    end else begin
      we_even = wr && !p_chan;
      we_odd  = wr && p_chan;
      waddr   = p_addr;
      wdata   = inc;
    end
    count = (!p_acc && p_ok) ? base : '0;
  end

  always_ff @(posedge clk) begin
    if (we_even) begin
      even_mem[waddr] <= wdata;
    end
    if (req.rd) begin
      rd_even <= even_mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we_odd) begin
      odd_mem[waddr] <= wdata;
    end
    if (req.rd) begin
      rd_odd <= odd_mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      p_chan   <= req.chan;
      p_addr   <= req.addr;
      p_ok     <= req.ok;
      p_acc    <= req.accumulate;
      p_en     <= req.count_en;
      fwd      <= wr && (req.chan == p_chan) && (req.addr == p_addr);
      fwd_data <= inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + bin_addr_t'(1);
      if (clr_addr == bin_addr_t'(BIN_COUNT - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/iq_sample_histogram_minmax_top.sv =====
// Interleaved sample statistics: per-channel extremes, sample total and bin histograms.
// Items pass stage s1 and then the output registers; one item per cycle when unstalled.
// The bin memories are read at acceptance and written back as the item enters the output stage.
// Reset is synchronous; afterwards all 65536 entries of both bin memories are zeroed
// (one entry of each per cycle), during which no item is accepted.
// Configuration writes are taken at any time, including during the clearing pass.
module iq_sample_histogram_minmax_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                mode,
  input  iqhist_pkg::sample_t                 sample,
  input  logic                                starts_buffer,
  input  logic                                query_channel,
  input  iqhist_pkg::sample_t                 query_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output iqhist_pkg::sample_t                 even_min,
  output iqhist_pkg::sample_t                 even_max,
  output iqhist_pkg::sample_t                 odd_min,
  output iqhist_pkg::sample_t                 odd_max,
  output logic [iqhist_pkg::OUT_BITS-1:0]     bin_count,
  output logic [iqhist_pkg::OUT_BITS-1:0]     sample_total
);
  import iqhist_pkg::*;

  logic    histogram_enable;
  sample_t even_low;
  sample_t even_high;
  sample_t odd_low;
  sample_t odd_high;
  logic    odd_next;
  count_t  seen_count;

  logic    s1_valid;
  sample_t s1_even_low;
  sample_t s1_even_high;
  sample_t s1_odd_low;
  sample_t s1_odd_high;
  count_t  s1_total;

  sample_t even_low_next;
  sample_t even_high_next;
  sample_t odd_low_next;
  sample_t odd_high_next;
  logic    odd_next_next;
  count_t  seen_count_next;

  logic    accept;
  logic    accumulate;
  logic    parity;
  logic    s1_adv;
  logic    retire;
  logic    clearing;
  count_t  bin_value;
  logic signed [SAMPLE_BITS+1:0] offset;
  bin_req_t req;

  assign cfg_ready = 1'b1;
  assign s1_adv    = !out_valid || out_ready;
  assign retire    = s1_valid && s1_adv;
  assign in_ready  = !clearing && (!s1_valid || s1_adv);
  assign accept    = in_valid && in_ready;

  always_comb begin
    accumulate      = mode_t'(mode) == MODE_ACCUMULATE;
    parity          = starts_buffer ? 1'b0 : odd_next;
    offset          = bin_offset(accumulate ? sample : query_value);
    even_low_next   = even_low;
    even_high_next  = even_high;
    odd_low_next    = odd_low;
    odd_high_next   = odd_high;
    odd_next_next   = odd_next;
    seen_count_next = seen_count;
    if (accumulate) begin
      if (!parity) begin
        if (sample < even_low) even_low_next = sample;
        if (sample > even_high) even_high_next = sample;
      end else begin
        if (sample < odd_low) odd_low_next = sample;
        if (sample > odd_high) odd_high_next = sample;
      end
      odd_next_next   = !parity;
      seen_count_next = sat_inc(seen_count);
    end
    req.rd         = accept;
    req.chan       = accumulate ? parity : query_channel;
    req.addr       = offset[BIN_BITS-1:0];
    req.ok         = bin_in_range(offset);
    req.accumulate = accumulate;
    req.count_en   = histogram_enable;
  end

  iqhist_bins u_bins (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .retire   (retire),
    .count    (bin_value),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      histogram_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      histogram_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      even_low   <= sample_t'(16'sh7fff);
      even_high  <= sample_t'(16'sh8000);
      odd_low    <= sample_t'(16'sh7fff);
      odd_high   <= sample_t'(16'sh8000);
      odd_next   <= 1'b0;
      seen_count <= '0;
    end else if (accept) begin
      even_low   <= even_low_next;
      even_high  <= even_high_next;
      odd_low    <= odd_low_next;
      odd_high   <= odd_high_next;
      odd_next   <= odd_next_next;
      seen_count <= seen_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_even_low  <= even_low_next;
      s1_even_high <= even_high_next;
      s1_odd_low   <= odd_low_next;
      s1_odd_high  <= odd_high_next;
      s1_total     <= seen_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      even_min     <= s1_even_low;
      even_max     <= s1_even_high;
      odd_min      <= s1_odd_low;
      odd_max      <= s1_odd_high;
      bin_count    <= to_out(bin_value);
      sample_total <= to_out(s1_total);
    end
  end

endmodule

// ===== sv/iqhist_checker.sv =====
// Port-level checker for the sample histogram block, bound to the top level.
module iqhist_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input iqhist_pkg::sample_t             even_min,
  input iqhist_pkg::sample_t             even_max,
  input iqhist_pkg::sample_t             odd_min,
  input iqhist_pkg::sample_t             odd_max,
  input logic [iqhist_pkg::OUT_BITS-1:0] bin_count,
  input logic [iqhist_pkg::OUT_BITS-1:0] sample_total
);

  a_reset_no_output: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("A result is offered straight after reset.");

  a_reset_clears_first: assert property (@(posedge clk) $past(rst) |-> !in_ready)
    else $error("An item can be accepted before the bins are cleared.");

  a_two_cycle_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && out_ready) ##1 out_ready |=> out_valid)
    else $error("An accepted item did not reach the output in two cycles.");

  a_extremes_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((even_min <= even_max) ||
                   (even_min == 16'sh7fff && even_max == 16'sh8000)) &&
                  ((odd_min <= odd_max) ||
                   (odd_min == 16'sh7fff && odd_max == 16'sh8000)))
    else $error("A channel reports a minimum above its maximum.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_total) && $stable(bin_count))
    else $error("A stalled result changed before it was taken.");

endmodule

bind iq_sample_histogram_minmax_top iqhist_checker u_iqhist_checker (.*);
